/* rtl/core/gfd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gfd_pkg
// Shared types, constants and helpers of the GIF frame delay parser.
// ----------------------------------------------------------------------------
package gfd_pkg;

  localparam int POSITION_BITS = 27;
  localparam int DELAY_W       = 16;
  localparam int DELAY_MS_W    = 20;
  localparam int FRAME_W       = 16;
  localparam int MAX_BYTES_W   = 27;
  localparam int SKIP_W        = 10;
  localparam int FIELD_W       = 4;
  localparam int CFG_INDEX_W   = 1;
  localparam int CFG_DATA_W    = 27;

  localparam logic [DELAY_W-1:0]     DEFAULT_DELAY_RST = 16'd100;
  localparam logic [MAX_BYTES_W-1:0] MAX_BYTES_RST     = 27'd67108864;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_DELAY = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_BYTES     = 1'd1;

  // block introducers and labels
  localparam logic [7:0] BYTE_TRAILER   = 8'h3B;
  localparam logic [7:0] BYTE_EXTENSION = 8'h21;
  localparam logic [7:0] BYTE_GCE_LABEL = 8'hF9;
  localparam logic [7:0] BYTE_IMAGE     = 8'h2C;
  localparam logic [7:0] GCE_BODY_SIZE  = 8'h04;

  typedef enum logic [1:0] {
    KIND_FRAME = 2'd0,
    KIND_OK    = 2'd1,
    KIND_FAIL  = 2'd2
  } gfd_kind_t;

  typedef enum logic [12:0] {
    PH_HEADER    = 13'h0001,
    PH_GCT       = 13'h0002,
    PH_BLOCK     = 13'h0004,
    PH_EXT_LABEL = 13'h0008,
    PH_GCE_SIZE  = 13'h0010,
    PH_GCE_BODY  = 13'h0020,
    PH_EXT_LEN   = 13'h0040,
    PH_EXT_DATA  = 13'h0080,
    PH_DESC      = 13'h0100,
    PH_LCT       = 13'h0200,
    PH_LZW       = 13'h0400,
    PH_IMG_LEN   = 13'h0800,
    PH_IMG_DATA  = 13'h1000
  } gfd_phase_t;

  typedef struct packed {
    gfd_kind_t              result_kind;
    logic [DELAY_MS_W-1:0]  delay_ms;
    logic [FRAME_W-1:0]     frame_number;
    logic                   last_of_run;
  } gfd_result_t;

  // results produced by one beat, in order
  typedef struct packed {
    logic [1:0]  count;
    gfd_result_t r0;
    gfd_result_t r1;
  } gfd_push_t;

  // "GIF8"
  function automatic logic [7:0] sig_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h47;
      2'd1:    b = 8'h49;
      2'd2:    b = 8'h46;
      default: b = 8'h38;
    endcase
    return b;
  endfunction

  // color table size in bytes from a packed field byte
  function automatic logic [SKIP_W-1:0] table_bytes(input logic [7:0] packed_b);
    logic [SKIP_W-1:0] n;
    n = SKIP_W'(2) << packed_b[2:0];
    return packed_b[7] ? ((n << 1) + n) : '0;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/gfd_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gfd_in_if / gfd_out_if
// Valid/ready channels for file bytes and parse results.
// ----------------------------------------------------------------------------
interface gfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;

  modport source (output valid, output data_byte, output end_of_file, input ready);
  modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface gfd_out_if import gfd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  gfd_kind_t             result_kind;
  logic [DELAY_MS_W-1:0] delay_ms;
  logic [FRAME_W-1:0]    frame_number;
  logic                  last_of_run;

  modport source (output valid, output result_kind, output delay_ms,
                  output frame_number, output last_of_run, input ready);
  modport sink   (input valid, input result_kind, input delay_ms,
                  input frame_number, input last_of_run, output ready);
endinterface
`default_nettype wire

/* rtl/core/gfd_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gfd_parser
// Block chain walker: one byte per beat, up to two results per beat.
// ----------------------------------------------------------------------------
module gfd_parser import gfd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic [7:0]             data_byte,
  input  logic                   end_of_file,
  input  logic [DELAY_W-1:0]     default_delay_ms,
  input  logic [MAX_BYTES_W-1:0] max_file_bytes,
  output gfd_push_t              push
);

  localparam int CMP_W = (POSITION_BITS > MAX_BYTES_W) ? POSITION_BITS : MAX_BYTES_W;
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  gfd_phase_t               parse_phase, parse_phase_next;
  logic [POSITION_BITS-1:0] byte_position, byte_position_next;
  logic [SKIP_W-1:0]        skip_remaining, skip_remaining_next;
  logic [FIELD_W-1:0]       field_index, field_index_next;
  logic [DELAY_W-1:0]       pending_delay, pending_delay_next;
  logic                     delay_present, delay_present_next;
  logic [FRAME_W-1:0]       frames_seen, frames_seen_next;
  logic                     signature_ok, signature_ok_next;
  logic                     status_sent, status_sent_next;

  logic                  do_frame, do_status, status_fail;
  logic [FRAME_W-1:0]    frames_after;
  logic [DELAY_MS_W-1:0] frame_delay;
  logic [DELAY_MS_W-1:0] delay_wide;
  logic [SKIP_W-1:0]     tbl;
  logic [SKIP_W-1:0]     skip_dec;
  logic                  over_limit;
  gfd_result_t           frame_res, status_res;

  assign tbl        = table_bytes(data_byte);
  assign skip_dec   = (skip_remaining != '0) ? skip_remaining - 1'b1 : skip_remaining;
  assign over_limit = CMP_W'(byte_position) >= CMP_W'(max_file_bytes);
  assign delay_wide = DELAY_MS_W'(pending_delay);

  always_comb begin
    parse_phase_next    = parse_phase;
    byte_position_next  = byte_position;
    skip_remaining_next = skip_remaining;
    field_index_next    = field_index;
    pending_delay_next  = pending_delay;
    delay_present_next  = delay_present;
    signature_ok_next   = signature_ok;
    do_frame            = 1'b0;
    do_status           = 1'b0;
    status_fail         = 1'b0;

    if (!status_sent) begin
      if (over_limit) begin
        do_status   = 1'b1;
        status_fail = 1'b1;
      end else begin
        case (parse_phase)
          PH_HEADER: begin
            if (byte_position <= POSITION_BITS'(3) &&
                data_byte != sig_byte(byte_position[1:0])) begin
              signature_ok_next = 1'b0;
            end
            if (byte_position == POSITION_BITS'(3) && !signature_ok_next) begin
              do_status   = 1'b1;
              status_fail = 1'b1;
            end else begin
              if (byte_position == POSITION_BITS'(10)) skip_remaining_next = tbl;
              if (byte_position == POSITION_BITS'(12))
                parse_phase_next = (skip_remaining != '0) ? PH_GCT : PH_BLOCK;
            end
          end
          PH_GCT: begin
            skip_remaining_next = skip_dec;
            if (skip_dec == '0) parse_phase_next = PH_BLOCK;
          end
          PH_BLOCK: begin
            if (data_byte == BYTE_TRAILER) begin
              do_status = 1'b1;
            end else if (data_byte == BYTE_EXTENSION) begin
              parse_phase_next = PH_EXT_LABEL;
            end else if (data_byte == BYTE_IMAGE) begin
              parse_phase_next = PH_DESC;
              field_index_next = '0;
            end else begin
              do_status   = 1'b1;
              status_fail = 1'b1;
            end
          end
          PH_EXT_LABEL: begin
            parse_phase_next = (data_byte == BYTE_GCE_LABEL) ? PH_GCE_SIZE : PH_EXT_LEN;
          end
          PH_GCE_SIZE: begin
            if (data_byte != GCE_BODY_SIZE) begin
              do_status   = 1'b1;
              status_fail = 1'b1;
            end else begin
              parse_phase_next = PH_GCE_BODY;
              field_index_next = '0;
            end
          end
          PH_GCE_BODY: begin
            if (field_index == FIELD_W'(1)) begin
              pending_delay_next[7:0] = data_byte;
            end else if (field_index == FIELD_W'(2)) begin
              pending_delay_next[15:8] = data_byte;
              delay_present_next       = 1'b1;
            end
            if (field_index >= FIELD_W'(3)) parse_phase_next = PH_EXT_LEN;
            field_index_next = field_index + 1'b1;
          end
          PH_EXT_LEN, PH_IMG_LEN: begin
            if (data_byte == 8'd0) begin
              do_frame         = (parse_phase == PH_IMG_LEN);
              parse_phase_next = PH_BLOCK;
            end else begin
              skip_remaining_next = SKIP_W'(data_byte);
              parse_phase_next = (parse_phase == PH_IMG_LEN) ? PH_IMG_DATA : PH_EXT_DATA;
            end
          end
          PH_EXT_DATA, PH_IMG_DATA: begin
            skip_remaining_next = skip_dec;
            if (skip_dec == '0)
              parse_phase_next = (parse_phase == PH_IMG_DATA) ? PH_IMG_LEN : PH_EXT_LEN;
          end
          PH_DESC: begin
            if (field_index >= FIELD_W'(8)) begin
              skip_remaining_next = tbl;
              parse_phase_next    = (tbl != '0) ? PH_LCT : PH_LZW;
            end
            field_index_next = field_index + 1'b1;
          end
          PH_LCT: begin
            skip_remaining_next = skip_dec;
            if (skip_dec == '0) parse_phase_next = PH_LZW;
          end
          PH_LZW: begin
            parse_phase_next = PH_IMG_LEN;
          end
          default: begin
            do_status   = 1'b1;
            status_fail = 1'b1;
          end
        endcase

        if (byte_position != POS_MAX) byte_position_next = byte_position + 1'b1;

        // last byte with no status yet: close out the file
        if (end_of_file && !do_status) begin
          do_status = 1'b1;
          case (parse_phase_next)
            PH_EXT_LABEL, PH_GCE_SIZE, PH_GCE_BODY, PH_DESC, PH_LCT, PH_LZW: begin
              status_fail = 1'b1;
            end
            PH_IMG_LEN, PH_IMG_DATA: begin
              do_frame = 1'b1;
            end
            default: begin
              status_fail = 1'b0;
            end
          endcase
        end
      end
    end

    if (do_frame) begin
      pending_delay_next = '0;
      delay_present_next = 1'b0;
    end
  end

  // x10 as two shifts and an add
  assign frame_delay  = (delay_present && pending_delay != '0) ?
                        ((delay_wide << 3) + (delay_wide << 1)) :
                        DELAY_MS_W'(default_delay_ms);
  assign frames_after = (do_frame && frames_seen != '1) ? frames_seen + 1'b1 : frames_seen;
  assign frames_seen_next = frames_after;
  assign status_sent_next = status_sent | do_status;

  always_comb begin
    frame_res.result_kind  = KIND_FRAME;
    frame_res.delay_ms     = frame_delay;
    frame_res.frame_number = frames_seen;
    frame_res.last_of_run  = !do_status;

    status_res.result_kind  = (status_fail || frames_after == '0) ? KIND_FAIL : KIND_OK;
    status_res.delay_ms     = '0;
    status_res.frame_number = frames_after;
    status_res.last_of_run  = 1'b1;

    push.r1 = status_res;
    if (do_frame) begin
      push.r0    = frame_res;
      push.count = accept ? (do_status ? 2'd2 : 2'd1) : 2'd0;
    end else begin
      push.r0    = status_res;
      push.count = (accept && do_status) ? 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase    <= PH_HEADER;
      byte_position  <= '0;
      skip_remaining <= '0;
      field_index    <= '0;
      pending_delay  <= '0;
      delay_present  <= 1'b0;
      frames_seen    <= '0;
      signature_ok   <= 1'b1;
      status_sent    <= 1'b0;
    end else if (accept) begin
      if (end_of_file) begin
        // last byte rearms the walker
        parse_phase    <= PH_HEADER;
        byte_position  <= '0;
        skip_remaining <= '0;
        field_index    <= '0;
        pending_delay  <= '0;
        delay_present  <= 1'b0;
        frames_seen    <= '0;
        signature_ok   <= 1'b1;
        status_sent    <= 1'b0;
      end else begin
        parse_phase    <= parse_phase_next;
        byte_position  <= byte_position_next;
        skip_remaining <= skip_remaining_next;
        field_index    <= field_index_next;
        pending_delay  <= pending_delay_next;
        delay_present  <= delay_present_next;
        frames_seen    <= frames_seen_next;
        signature_ok   <= signature_ok_next;
        status_sent    <= status_sent_next;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/gfd_result_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gfd_result_fifo
// Four-entry result queue: up to two results in per cycle, one out when ready.
// ----------------------------------------------------------------------------
module gfd_result_fifo import gfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  gfd_push_t   push,
  output logic        space_ok,
  output logic        out_valid,
  input  logic        out_ready,
  output gfd_result_t out_data
);

  gfd_result_t entries [4];
  logic [1:0]  rd_ptr, wr_ptr;
  logic [2:0]  count;
  logic        pop;
  logic [1:0]  wr_ptr_p1;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 3'd0);
  assign out_data  = entries[rd_ptr];
  // room for a full two-result beat
  assign space_ok  = (count <= 3'd2);
  assign wr_ptr_p1 = wr_ptr + 1'b1;

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) entries[wr_ptr] <= push.r0;
    if (push.count == 2'd2) entries[wr_ptr_p1] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push.count;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + 3'(push.count) - 3'(pop);
    end
  end

endmodule
`default_nettype wire

/* rtl/core/gif_frame_delay_parser_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gif_frame_delay_parser_unit
// GIF block chain walker: emits frame delays in ms and one final status.
// ----------------------------------------------------------------------------
// Each result is written into the result queue and offered from its head.
// Throughput: one byte per cycle; a byte causing two results hands them out
//   one at a time, absorbed by the four-entry result queue (input stalls
//   while three or more results are queued).
// Reset (rst, synchronous): walker to header phase, queue emptied,
//   default_delay_ms = 100, max_file_bytes = 67108864.
module gif_frame_delay_parser_unit import gfd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  gfd_in_if.sink                 in_ch,
  gfd_out_if.source              out_ch,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data
);

  logic [DELAY_W-1:0]     default_delay_ms;
  logic [MAX_BYTES_W-1:0] max_file_bytes;
  logic                   accept;
  logic                   space_ok;
  gfd_push_t              push;
  gfd_result_t            head;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_delay_ms <= DEFAULT_DELAY_RST;
      max_file_bytes   <= MAX_BYTES_RST;
    end else if (wr_en) begin
      case (wr_index)
        CFG_DEFAULT_DELAY: default_delay_ms <= wr_data[DELAY_W-1:0];
        CFG_MAX_BYTES:     max_file_bytes   <= wr_data[MAX_BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = space_ok;
  assign accept      = in_ch.valid && space_ok;

  gfd_parser u_parser (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .data_byte        (in_ch.data_byte),
    .end_of_file      (in_ch.end_of_file),
    .default_delay_ms (default_delay_ms),
    .max_file_bytes   (max_file_bytes),
    .push             (push)
  );

  gfd_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .space_ok  (space_ok),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (head)
  );

  assign out_ch.result_kind  = head.result_kind;
  assign out_ch.delay_ms     = head.delay_ms;
  assign out_ch.frame_number = head.frame_number;
  assign out_ch.last_of_run  = head.last_of_run;

endmodule
`default_nettype wire

/* test/tb_gif_frame_delay_parser_unit.sv */
// ----------------------------------------------------------------------------
// tb_gif_frame_delay_parser_unit
// Streams GIF files through the parser one byte per beat. Most files are
// well formed with random content; the rest are truncated, corrupted or
// noise. A scoreboard walks each file in step with the block to predict the
// frame delays and statuses, and it checks them in order. The run covers
// several register settings and several sender and receiver idling patterns.
// It also includes one long receiver hold-off that fills the result queue.
// ----------------------------------------------------------------------------
module tb_gif_frame_delay_parser_unit;
  import gfd_pkg::*;

  class gif_parse_scoreboard;
    localparam logic [31:0] GIF_SIG = 32'h47494638;  // "GIF8"

    gfd_result_t awaited_results[$];
    gfd_result_t beat_results[$];
    int unsigned mismatches;

    logic [DELAY_W-1:0]     default_ms;
    logic [MAX_BYTES_W-1:0] byte_limit;

    gfd_phase_t         phase;
    logic [26:0]        pos;
    logic [SKIP_W-1:0]  skip_left;
    logic [FIELD_W-1:0] field;
    logic [15:0]        gce_delay;
    bit                 gce_seen;
    logic [15:0]        frame_cnt;
    bit                 sig_match;
    bit                 status_done;

    function new();
      default_ms  = DEFAULT_DELAY_RST;
      byte_limit  = MAX_BYTES_RST;
      mismatches  = 0;
      rearm();
    endfunction

    function void rearm();
      phase       = PH_HEADER;
      pos         = '0;
      skip_left   = '0;
      field       = '0;
      gce_delay   = '0;
      gce_seen    = 1'b0;
      frame_cnt   = '0;
      sig_match   = 1'b1;
      status_done = 1'b0;
    endfunction

    function void note_config(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_DEFAULT_DELAY) default_ms = val[DELAY_W-1:0];
      else byte_limit = val[MAX_BYTES_W-1:0];
    endfunction

    function void add(gfd_kind_t k, logic [DELAY_MS_W-1:0] d);
      gfd_result_t r;
      r.result_kind  = k;
      r.delay_ms     = d;
      r.frame_number = frame_cnt;
      r.last_of_run  = 1'b0;
      beat_results.push_back(r);
    endfunction

    function void frame_done();
      logic [DELAY_MS_W-1:0] d;
      d = (gce_seen && gce_delay != 16'd0) ? DELAY_MS_W'(gce_delay) * 20'd10
                                           : DELAY_MS_W'(default_ms);
      add(KIND_FRAME, d);
      if (frame_cnt != 16'hFFFF) frame_cnt++;
      gce_delay = '0;
      gce_seen  = 1'b0;
    endfunction

    function void status(bit fail);
      add((fail || frame_cnt == 16'd0) ? KIND_FAIL : KIND_OK, '0);
      status_done = 1'b1;
    endfunction

    function logic [SKIP_W-1:0] palette_len(logic [7:0] pk);
      return pk[7] ? SKIP_W'(3 * (32'd2 << pk[2:0])) : '0;
    endfunction

    function void walk_byte(logic [7:0] b);
      case (phase)
        PH_HEADER: begin
          if (pos < 27'd4 && b != GIF_SIG[8*(3 - pos[1:0]) +: 8]) sig_match = 1'b0;
          if (pos == 27'd3 && !sig_match) begin
            status(1'b1);
            return;
          end
          if (pos == 27'd10) skip_left = palette_len(b);
          if (pos == 27'd12) phase = (skip_left != '0) ? PH_GCT : PH_BLOCK;
        end
        PH_GCT, PH_LCT: begin
          if (skip_left != '0) skip_left--;
          if (skip_left == '0) phase = (phase == PH_GCT) ? PH_BLOCK : PH_LZW;
        end
        PH_BLOCK: begin
          if (b == BYTE_TRAILER) status(1'b0);
          else if (b == BYTE_EXTENSION) phase = PH_EXT_LABEL;
          else if (b == BYTE_IMAGE) begin
            phase = PH_DESC;
            field = '0;
          end else status(1'b1);
        end
        PH_EXT_LABEL: phase = (b == BYTE_GCE_LABEL) ? PH_GCE_SIZE : PH_EXT_LEN;
        PH_GCE_SIZE: begin
          if (b != GCE_BODY_SIZE) begin
            status(1'b1);
            return;
          end
          phase = PH_GCE_BODY;
          field = '0;
        end
        PH_GCE_BODY: begin
          if (field == 4'd1) gce_delay[7:0] = b;
          else if (field == 4'd2) begin
            gce_delay[15:8] = b;
            gce_seen = 1'b1;
          end
          if (field >= 4'd3) phase = PH_EXT_LEN;
          field = field + 4'd1;
        end
        PH_EXT_LEN, PH_IMG_LEN: begin
          if (b == 8'h00) begin
            if (phase == PH_IMG_LEN) frame_done();
            phase = PH_BLOCK;
          end else begin
            skip_left = SKIP_W'(b);
            phase = (phase == PH_IMG_LEN) ? PH_IMG_DATA : PH_EXT_DATA;
          end
        end
        PH_EXT_DATA, PH_IMG_DATA: begin
          if (skip_left != '0) skip_left--;
          if (skip_left == '0) phase = (phase == PH_IMG_DATA) ? PH_IMG_LEN : PH_EXT_LEN;
        end
        PH_DESC: begin
          if (field >= 4'd8) begin
            skip_left = palette_len(b);
            phase = (skip_left != '0) ? PH_LCT : PH_LZW;
          end
          field = field + 4'd1;
        end
        PH_LZW: phase = PH_IMG_LEN;
        default: status(1'b1);
      endcase
    endfunction

    function void close_file();
      case (phase)
        PH_EXT_LABEL, PH_GCE_SIZE, PH_GCE_BODY, PH_DESC, PH_LCT, PH_LZW: status(1'b1);
        PH_IMG_LEN, PH_IMG_DATA: begin
          frame_done();
          status(1'b0);
        end
        default: status(1'b0);
      endcase
    endfunction

    // called for every accepted input beat
    function void note_byte(logic [7:0] b, bit eof);
      gfd_result_t r;
      beat_results.delete();
      if (!status_done) begin
        if (pos >= byte_limit) status(1'b1);
        else begin
          walk_byte(b);
          if (pos != '1) pos++;
          if (eof && !status_done) close_file();
        end
      end
      if (beat_results.size() > 0) begin
        r = beat_results.pop_back();
        r.last_of_run = 1'b1;
        beat_results.push_back(r);
      end
      foreach (beat_results[i]) awaited_results.push_back(beat_results[i]);
      if (eof) rearm();
    endfunction

    // called for every accepted result beat
    function void check_result(gfd_result_t got);
      gfd_result_t want;
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result kind %0d delay %0d frame %0d last %0b",
                   got.result_kind, got.delay_ms, got.frame_number, got.last_of_run);
        return;
      end
      want = awaited_results.pop_front();
      if (got.result_kind !== want.result_kind || got.delay_ms !== want.delay_ms ||
          got.frame_number !== want.frame_number || got.last_of_run !== want.last_of_run) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: exp kind %0d delay %0d frame %0d last %0b,",
                   want.result_kind, want.delay_ms, want.frame_number, want.last_of_run,
                   " got kind %0d delay %0d frame %0d last %0b",
                   got.result_kind, got.delay_ms, got.frame_number, got.last_of_run);
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   wr_en;
  logic [CFG_INDEX_W-1:0] wr_index;
  logic [CFG_DATA_W-1:0]  wr_data;

  gfd_in_if  in_ch ();
  gfd_out_if out_ch ();

  gif_frame_delay_parser_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  gif_parse_scoreboard sb;
  gfd_result_t         beat_seen;
  logic [7:0]          file_q[$];
  int unsigned         items_sent;
  int unsigned         idle_in_pct;
  int unsigned         stall_pct;
  bit                  hold_armed;
  bit                  hold_done;
  int unsigned         hold_left;

  always #4 clk = ~clk;

  initial begin
    #2000000;
    $display("gif_frame_delay_parser_unit: mismatch");
    $finish;
  end

  // result side: check, random stalls and the one long hold-off
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      beat_seen.result_kind  = out_ch.result_kind;
      beat_seen.delay_ms     = out_ch.delay_ms;
      beat_seen.frame_number = out_ch.frame_number;
      beat_seen.last_of_run  = out_ch.last_of_run;
      sb.check_result(beat_seen);
    end
    if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
      if (hold_left == 1) hold_done <= 1'b1;
    end else if (hold_armed && !hold_done) begin
      out_ch.ready <= 1'b0;
      hold_left <= 300;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit eof);
    while ($urandom_range(99) < idle_in_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= b;
    in_ch.end_of_file <= eof;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_byte(b, eof);
    items_sent++;
  endtask

  task automatic send_file();
    foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1);
  endtask

  // block must be idle: both registers written back to back
  task automatic set_regs(input logic [DELAY_W-1:0] dly, input logic [MAX_BYTES_W-1:0] lim);
    wr_en    <= 1'b1;
    wr_index <= CFG_DEFAULT_DELAY;
    wr_data  <= CFG_DATA_W'(dly);
    @(posedge clk);
    sb.note_config(CFG_DEFAULT_DELAY, CFG_DATA_W'(dly));
    wr_index <= CFG_MAX_BYTES;
    wr_data  <= CFG_DATA_W'(lim);
    @(posedge clk);
    sb.note_config(CFG_MAX_BYTES, CFG_DATA_W'(lim));
    wr_en <= 1'b0;
  endtask

  task automatic wait_idle();
    int unsigned guard;
    guard = 0;
    in_ch.valid <= 1'b0;
    while (sb.awaited_results.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    // a trailing byte may produce nothing; give the pipe time to settle
    repeat (4) @(posedge clk);
  endtask

  task automatic push_rand(input int n);
    repeat (n) file_q.push_back(8'($urandom));
  endtask

  task automatic push_chain(input int n_sub, input int max_len);
    int len;
    repeat (n_sub) begin
      len = $urandom_range(max_len, 1);
      file_q.push_back(8'(len));
      push_rand(len);
    end
    file_q.push_back(8'h00);
  endtask

  // color table flags: mostly tiny tables, rarely the 256-entry one
  function automatic logic [7:0] palette_flags();
    logic [7:0] pk;
    pk = 8'($urandom);
    if ($urandom_range(49) != 0) pk[2:0] = 3'($urandom_range(1, 0));
    return pk;
  endfunction

  task automatic push_palette(input logic [7:0] pk);
    if (pk[7]) push_rand(3 * (2 << pk[2:0]));
  endtask

  task automatic build_gif();
    logic [7:0] pk;
    logic [7:0] b;
    int         len;
    file_q.delete();
    file_q.push_back(8'h47);
    file_q.push_back(8'h49);
    file_q.push_back(8'h46);
    file_q.push_back(8'h38);
    file_q.push_back($urandom_range(1) ? 8'h39 : 8'h37);
    file_q.push_back(8'h61);
    push_rand(4);
    pk = palette_flags();
    file_q.push_back(pk);
    push_rand(2);
    push_palette(pk);
    repeat ($urandom_range(3, 0)) begin
      if ($urandom_range(2) == 0) begin
        file_q.push_back(BYTE_EXTENSION);
        b = 8'($urandom);
        if (b == BYTE_GCE_LABEL) b = 8'hFE;
        file_q.push_back(b);
        push_chain($urandom_range(2, 0), 6);
      end
      // zero, one or two GCEs; the last one should win
      repeat ($urandom_range(2, 0)) begin
        file_q.push_back(BYTE_EXTENSION);
        file_q.push_back(BYTE_GCE_LABEL);
        file_q.push_back($urandom_range(19) == 0 ? 8'($urandom_range(255, 5)) : GCE_BODY_SIZE);
        push_rand(1);
        case ($urandom_range(3))
          0: begin
            file_q.push_back(8'h00);
            file_q.push_back(8'h00);
          end
          1: begin
            file_q.push_back(8'hFF);
            file_q.push_back(8'hFF);
          end
          default: push_rand(2);
        endcase
        push_rand(1);
        push_chain($urandom_range(4) == 0 ? 1 : 0, 4);
      end
      if ($urandom_range(29) == 0) begin
        b = 8'($urandom);
        if (b == BYTE_EXTENSION || b == BYTE_IMAGE || b == BYTE_TRAILER) b = 8'h00;
        file_q.push_back(b);
      end
      file_q.push_back(BYTE_IMAGE);
      push_rand(8);
      pk = palette_flags();
      file_q.push_back(pk);
      push_palette(pk);
      push_rand(1);
      push_chain($urandom_range(2, 0), 8);
    end
    if ($urandom_range(9) != 0) file_q.push_back(BYTE_TRAILER);
    if ($urandom_range(4) == 0) push_rand($urandom_range(3, 1));
    if ($urandom_range(4) == 0) begin
      len = $urandom_range(file_q.size(), 1);
      while (file_q.size() > len) void'(file_q.pop_back());
    end
    if ($urandom_range(9) == 0) file_q[$urandom_range(file_q.size() - 1)] = 8'($urandom);
  endtask

  task automatic build_noise();
    file_q.delete();
    if ($urandom_range(1)) begin
      file_q.push_back(8'h47);
      file_q.push_back(8'h49);
      file_q.push_back(8'h46);
    end
    push_rand($urandom_range(6, 1));
  endtask

  initial begin
    clk               = 1'b0;
    rst               = 1'b1;
    wr_en             = 1'b0;
    wr_index          = '0;
    wr_data           = '0;
    in_ch.valid       = 1'b0;
    in_ch.data_byte   = '0;
    in_ch.end_of_file = 1'b0;
    out_ch.ready      = 1'b0;
    items_sent        = 0;
    idle_in_pct       = 0;
    stall_pct         = 0;
    hold_armed        = 1'b0;
    hold_done         = 1'b0;
    hold_left         = 0;
    sb = new();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // bad signature: failure on the fourth byte, which also ends the file
    file_q = '{8'h47, 8'h49, 8'h46, 8'h00};
    send_file();
    // last byte inside image data: frame, then success
    file_q = '{8'h47, 8'h49, 8'h46, 8'h38, 8'h39, 8'h61, 8'h01, 8'h00, 8'h01, 8'h00,
               8'h00, 8'h00, 8'h00, BYTE_IMAGE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
               8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h05, 8'hA5};
    send_file();

    for (int s = 0; s < 20; s++) begin
      if (s % 4 == 0) begin
        wait_idle();
        case (s / 4)
          0: set_regs(DEFAULT_DELAY_RST, MAX_BYTES_RST);
          1: set_regs(16'd0, 27'd14);
          2: set_regs(16'hFFFF, 27'd134217727);
          3: set_regs(16'($urandom), 27'($urandom_range(200, 14)));
          default: set_regs(16'($urandom), 27'($urandom_range(134217727, 1000)));
        endcase
      end
      case (s % 4)
        0: begin idle_in_pct = 0;  stall_pct = 0;  end
        1: begin idle_in_pct = 61; stall_pct = 0;  end
        2: begin idle_in_pct = 0;  stall_pct = 61; end
        default: begin idle_in_pct = 7; stall_pct = 7; end
      endcase
      if (s == 4) hold_armed <= 1'b1;
      // running byte budget, so a long file eats into the next segment
      while (items_sent < 48 * (s + 1)) begin
        if ($urandom_range(9) < 2) build_noise();
        else build_gif();
        send_file();
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (sb.awaited_results.size() != 0) begin
      $display("ERROR: %0d expected results never arrived", sb.awaited_results.size());
      sb.mismatches += sb.awaited_results.size();
    end
    if (sb.mismatches == 0) begin
      $display("gif_frame_delay_parser_unit: match");
    end else begin
      $display("gif_frame_delay_parser_unit: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/gfd_pkg.sv
rtl/core/gfd_if.sv
rtl/core/gfd_parser.sv
rtl/core/gfd_result_fifo.sv
rtl/core/gif_frame_delay_parser_unit.sv
test/tb_gif_frame_delay_parser_unit.sv
